// ===== hw/rtl/dcau_pkg.sv =====
// Package: shared constants and types for the difference constraint APSP update block.
package dcau_pkg;
	localparam int NUM_VARS   = 64;
	localparam int DIST_WIDTH = 32;
	localparam int VAR_W      = $clog2(NUM_VARS);
	localparam int ADDR_W     = 2 * VAR_W;
	localparam int DEPTH      = NUM_VARS * NUM_VARS;
	localparam int CNT_W      = 13;
	localparam int BOUND_W    = 25;
	localparam int OUT_W      = 32;

	typedef logic signed [DIST_WIDTH-1:0] dist_t;
	typedef logic [VAR_W-1:0] var_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam dist_t DIST_INF = dist_t'({1'b0, {(DIST_WIDTH-1){1'b1}}});
	localparam dist_t DIST_HI  = DIST_INF - dist_t'(1);
	localparam dist_t DIST_LO  = -DIST_INF;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REDUNDANT = 2'd1;
	localparam logic [1:0] ST_CONFLICT  = 2'd2;

	localparam logic FUNC_ASSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Saturating add; both operands lie within [DIST_LO, DIST_HI]
	function automatic dist_t sat_add(dist_t a, dist_t b);
		logic signed [DIST_WIDTH:0] s;
		s = (DIST_WIDTH+1)'(a) + (DIST_WIDTH+1)'(b);
		if (s > (DIST_WIDTH+1)'(DIST_HI)) return DIST_HI;
		if (s < (DIST_WIDTH+1)'(DIST_LO)) return DIST_LO;
		return s[DIST_WIDTH-1:0];
	endfunction

	function automatic addr_t cell_addr(var_t r, var_t c);
		return {r, c};
	endfunction
endpackage

// ===== hw/rtl/dcau_mem.sv =====
// Distance matrix memory: one write port, one registered read port.
module dcau_mem import dcau_pkg::*; (
	input  logic  clk,
	input  logic  we,
	input  addr_t waddr,
	input  dist_t wdata,
	input  addr_t raddr,
	output dist_t rdata
);
	dist_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/dcau_lists.sv =====
// Row and column set lists of the current item.
module dcau_lists import dcau_pkg::*; (
	input  logic clk,
	input  logic row_we,
	input  var_t row_waddr,
	input  var_t row_wdata,
	input  var_t row_raddr,
	output var_t row_rdata,
	input  logic col_we,
	input  var_t col_waddr,
	input  var_t col_wdata,
	input  var_t col_raddr,
	output var_t col_rdata
);
	var_t row_mem [NUM_VARS];
	var_t col_mem [NUM_VARS];

	// Row list
	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		row_rdata <= row_mem[row_raddr];
	end

	// Column list
	always_ff @(posedge clk) begin
		if (col_we) col_mem[col_waddr] <= col_wdata;
		col_rdata <= col_mem[col_raddr];
	end
endmodule

// ===== hw/rtl/difference_constraint_apsp_update_top.sv =====
// Top level: sequencer around the distance matrix memory and the set lists.
//
// Usage: drive func, from_var, to_var, bound, negated and pulse start while
// busy is low; the item is taken at that edge and busy rises. One result
// appears on status, distance and changed_entries, marked by done for a single
// cycle; busy falls in that same cycle. The receiver cannot stall.
//
// After reset a clearing pass writes every entry of the matrix, one entry a cycle,
// while busy is high.
// A read item passes through the read wait and read done states to the finishing
// state; a conflict or redundant assert ends after the checks of (b,a) and (a,b).
// An inserting assert then runs a row and column pass over every variable, and a
// closure over I x J when J is not empty: every matrix access goes through the
// single read port of the memory, and the read, compare and write back of one
// entry are done in sequence, so accesses never overlap.
// The next item can be taken in the cycle that carries the result.
// Reset clears the sequencer and restarts the clearing pass.
module difference_constraint_apsp_update_top import dcau_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [VAR_W-1:0]          from_var,
	input  logic [VAR_W-1:0]          to_var,
	input  logic signed [BOUND_W-1:0] bound,
	input  logic                      negated,
	output logic                      done,
	output logic [1:0]                status,
	output logic signed [OUT_W-1:0]   distance,
	output logic [CNT_W-1:0]          changed_entries
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_DONE,
		S_CHK_BA, S_CHK_AB, S_CHK_WAIT, S_CHK_EVAL,
		S_UA_RD, S_UA_WAIT, S_UB_WAIT, S_UB_EVAL,
		S_BU_RD, S_BU_WAIT, S_AU_WAIT, S_AU_EVAL,
		S_PX_LD, S_PX_WAIT, S_PY_LD, S_PY_WAIT,
		S_IB_WAIT, S_BJ_WAIT, S_IJ_WAIT, S_IJ_EVAL,
		S_FINISH
	} state_t;

	state_t state_q;
	addr_t  clr_q;
	var_t   a_q, b_q, u_q, i_q, j_q;
	var_t   f_q, t_q;
	logic   oob_q, func_q;
	dist_t  w_q, t1_q, cand_q;
	logic [VAR_W:0] ni_q, nj_q, x_q, y_q;
	logic [CNT_W-1:0] cnt_q;

	// Compare results registered in the cycle before write back
	dist_t cand_cmp_q;
	logic  upd_q;

	// Read item result held until the finishing cycle
	logic signed [OUT_W-1:0] rd_q;

	logic  mem_we;
	addr_t mem_waddr, mem_raddr;
	dist_t mem_wdata, mem_rdata;
	logic  row_we, col_we;
	var_t  row_rdata, col_rdata;

	dcau_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	dcau_lists u_lists (
		.clk(clk),
		.row_we(row_we), .row_waddr(ni_q[VAR_W-1:0]), .row_wdata(u_q),
		.row_raddr(x_q[VAR_W-1:0]), .row_rdata(row_rdata),
		.col_we(col_we), .col_waddr(nj_q[VAR_W-1:0]), .col_wdata(u_q),
		.col_raddr(y_q[VAR_W-1:0]), .col_rdata(col_rdata)
	);

	// Edge weight of the incoming item, saturated
	logic signed [BOUND_W:0] wraw;
	dist_t w_in;
	always_comb begin
		wraw = negated ? (-{bound[BOUND_W-1], bound} - (BOUND_W+1)'(1))
		               : {bound[BOUND_W-1], bound};
		w_in = dist_t'(wraw);
		if (w_in > DIST_HI) w_in = DIST_HI;
		if (w_in < DIST_LO) w_in = DIST_LO;
	end

	// Saturation of a read value to the output field
	localparam logic signed [DIST_WIDTH+OUT_W-1:0] OMAX =
		{{(DIST_WIDTH+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [DIST_WIDTH+OUT_W-1:0] OHI = OMAX - (DIST_WIDTH+OUT_W)'(1);
	localparam logic signed [DIST_WIDTH+OUT_W-1:0] OLO = -OMAX;
	logic signed [DIST_WIDTH+OUT_W-1:0] rd_ext;
	logic signed [OUT_W-1:0] rd_sat;
	always_comb begin
		rd_ext = (DIST_WIDTH+OUT_W)'(mem_rdata);
		if (mem_rdata == DIST_INF) rd_sat = {1'b0, {(OUT_W-1){1'b1}}};
		else if (rd_ext > OHI) rd_sat = OHI[OUT_W-1:0];
		else if (rd_ext < OLO) rd_sat = OLO[OUT_W-1:0];
		else rd_sat = rd_ext[OUT_W-1:0];
	end

	dist_t cand_ua, cand_bu, cand_ij;
	assign cand_ua = sat_add(t1_q, w_q);
	assign cand_bu = cand_ua;
	assign cand_ij = sat_add(t1_q, mem_rdata);

	// Memory address and write control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(a_q, b_q);
		mem_wdata = w_q;
		mem_raddr = cell_addr(a_q, b_q);
		row_we    = 1'b0;
		col_we    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q[ADDR_W-1:VAR_W] == clr_q[VAR_W-1:0]) ? '0 : DIST_INF;
			end
			S_IDLE:     mem_raddr = negated ? cell_addr(from_var, to_var)
			                                : cell_addr(to_var, from_var);
			S_RD_WAIT:  mem_raddr = cell_addr(f_q, t_q);
			S_CHK_AB:   mem_raddr = cell_addr(a_q, b_q);
			// Edge written only when it is neither a conflict nor redundant
			S_CHK_EVAL: mem_we = !oob_q && !(t1_q < -w_q) && (mem_rdata > w_q)
			                     && (a_q != b_q);
			S_UA_RD:    mem_raddr = cell_addr(u_q, a_q);
			S_UA_WAIT:  mem_raddr = cell_addr(u_q, b_q);
			S_UB_EVAL: begin
				mem_waddr = cell_addr(u_q, b_q);
				mem_wdata = cand_cmp_q;
				mem_we    = upd_q;
				row_we    = upd_q;
			end
			S_BU_RD:    mem_raddr = cell_addr(b_q, u_q);
			S_BU_WAIT:  mem_raddr = cell_addr(a_q, u_q);
			S_AU_EVAL: begin
				mem_waddr = cell_addr(a_q, u_q);
				mem_wdata = cand_cmp_q;
				mem_we    = upd_q;
				col_we    = upd_q;
			end
			S_PY_WAIT:  mem_raddr = cell_addr(i_q, b_q);
			S_IB_WAIT:  mem_raddr = cell_addr(b_q, col_rdata);
			S_BJ_WAIT:  mem_raddr = cell_addr(i_q, j_q);
			S_IJ_EVAL: begin
				mem_waddr = cell_addr(i_q, j_q);
				mem_wdata = cand_q;
				mem_we    = upd_q;
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			busy     <= 1'b1;
			done     <= 1'b0;
			status   <= ST_OK;
			distance <= '0;
			changed_entries <= '0;
			cnt_q    <= '0;
			ni_q     <= '0;
			nj_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			u_q      <= '0;
			upd_q    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(DEPTH-1)) begin
						state_q <= S_IDLE;
						busy    <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						busy   <= 1'b1;
						func_q <= func;
						f_q    <= from_var;
						t_q    <= to_var;
						oob_q  <= (32'(from_var) >= NUM_VARS) || (32'(to_var) >= NUM_VARS);
						a_q    <= negated ? to_var : from_var;
						b_q    <= negated ? from_var : to_var;
						w_q    <= w_in;
						state_q <= (func == FUNC_READ) ? S_RD_WAIT : S_CHK_BA;
					end
				end
				S_RD_WAIT: state_q <= S_RD_DONE;
				S_RD_DONE: begin
					// Read data of (from,to) is on the memory output here
					state_q <= S_FINISH;
				end
				S_CHK_BA: begin
					t1_q    <= mem_rdata;
					state_q <= S_CHK_AB;
				end
				S_CHK_AB: state_q <= S_CHK_WAIT;
				S_CHK_WAIT: state_q <= S_CHK_EVAL;
				S_CHK_EVAL: begin
					cnt_q <= CNT_W'(1);
					ni_q  <= '0;
					nj_q  <= '0;
					u_q   <= '0;
					if (oob_q) begin
						status  <= ST_REDUNDANT;
						changed_entries <= '0;
						state_q <= S_FINISH;
					end else if (t1_q < -w_q) begin
						status  <= ST_CONFLICT;
						changed_entries <= '0;
						state_q <= S_FINISH;
					end else if (mem_rdata <= w_q) begin
						status  <= ST_REDUNDANT;
						changed_entries <= '0;
						state_q <= S_FINISH;
					end else begin
						status  <= ST_OK;
						state_q <= S_UA_RD;
					end
				end
				// Row pass, first half: (u,a) then (u,b)
				S_UA_RD: state_q <= S_UA_WAIT;
				S_UA_WAIT: begin
					t1_q    <= mem_rdata;
					state_q <= S_UB_WAIT;
				end
				S_UB_WAIT: begin
					cand_cmp_q <= cand_ua;
					upd_q   <= (t1_q != DIST_INF) && (cand_ua < mem_rdata);
					state_q <= S_UB_EVAL;
				end
				S_UB_EVAL: begin
					if (upd_q) begin
						ni_q  <= ni_q + (VAR_W+1)'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					upd_q   <= 1'b0;
					state_q <= S_BU_RD;
				end
				// Second half: (b,u) then (a,u)
				S_BU_RD: state_q <= S_BU_WAIT;
				S_BU_WAIT: begin
					t1_q    <= mem_rdata;
					state_q <= S_AU_WAIT;
				end
				S_AU_WAIT: begin
					cand_cmp_q <= cand_bu;
					upd_q   <= (t1_q != DIST_INF) && (cand_bu < mem_rdata);
					state_q <= S_AU_EVAL;
				end
				S_AU_EVAL: begin
					if (upd_q) begin
						nj_q  <= nj_q + (VAR_W+1)'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					upd_q <= 1'b0;
					u_q   <= u_q + var_t'(1);
					if (u_q == var_t'(NUM_VARS-1)) begin
						x_q     <= '0;
						state_q <= S_PX_LD;
					end else begin
						state_q <= S_UA_RD;
					end
				end
				// Pair closure over I x J
				S_PX_LD: begin
					if (x_q == ni_q || nj_q == '0) state_q <= S_FINISH;
					else state_q <= S_PX_WAIT;
				end
				S_PX_WAIT: begin
					i_q     <= row_rdata;
					y_q     <= '0;
					state_q <= S_PY_LD;
				end
				S_PY_LD: begin
					if (y_q == nj_q) begin
						x_q     <= x_q + (VAR_W+1)'(1);
						state_q <= S_PX_LD;
					end else begin
						state_q <= S_PY_WAIT;
					end
				end
				S_PY_WAIT: state_q <= S_IB_WAIT;
				S_IB_WAIT: begin
					j_q     <= col_rdata;
					t1_q    <= mem_rdata;
					state_q <= S_BJ_WAIT;
				end
				S_BJ_WAIT: begin
					cand_q  <= cand_ij;
					state_q <= S_IJ_WAIT;
				end
				S_IJ_WAIT: begin
					upd_q   <= (i_q != j_q) && (cand_q < mem_rdata);
					state_q <= S_IJ_EVAL;
				end
				S_IJ_EVAL: begin
					if (upd_q && cnt_q != '1) cnt_q <= cnt_q + CNT_W'(1);
					upd_q   <= 1'b0;
					y_q     <= y_q + (VAR_W+1)'(1);
					state_q <= S_PY_LD;
				end
				S_FINISH: begin
					done  <= 1'b1;
					busy  <= 1'b0;
					if (func_q == FUNC_READ) begin
						status   <= ST_OK;
						distance <= oob_q ? {1'b0, {(OUT_W-1){1'b1}}} : rd_q;
						changed_entries <= '0;
					end else begin
						distance <= '0;
						if (status == ST_OK) changed_entries <= cnt_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the saturated read value
	always_ff @(posedge clk) begin
		if (state_q == S_RD_DONE) rd_q <= rd_sat;
	end

	// Result strobe only when leaving a busy item
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result without item");
	// No item is taken during the clearing pass
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy)
		else $error("idle during clearing");
	// Conflict and redundant results report no changes
	a_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> changed_entries == '0)
		else $error("changes reported for a rejected item");
	// Accepted start makes the block busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item not taken");
endmodule

// ===== test/dcau_checker.sv =====
// Checker: watches the item and result channels, predicts distance matrix updates, compares.
`timescale 1ns / 100ps
module dcau_checker import dcau_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      func,
	input  logic [VAR_W-1:0]          from_var,
	input  logic [VAR_W-1:0]          to_var,
	input  logic signed [BOUND_W-1:0] bound,
	input  logic                      negated,
	input  logic                      done,
	input  logic [1:0]                status,
	input  logic signed [OUT_W-1:0]   distance,
	input  logic [CNT_W-1:0]          changed_entries,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen,
	output int                        inserts_seen,
	output int                        conflicts_seen
);
	typedef struct packed {
		logic [1:0]        st;
		logic signed [31:0] dv;
		logic [CNT_W-1:0]  cnt;
	} outcome_t;

	// Shadow copy of the matrix, 64-bit values so sums never wrap
	longint shadow [NUM_VARS][NUM_VARS];
	outcome_t expected_q [$];
	int unsigned rows_i [$];
	int unsigned cols_j [$];

	localparam longint INF = longint'(DIST_INF);
	localparam longint HI  = INF - 1;
	localparam longint LO  = -INF;

	function automatic longint sat_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > HI) return HI;
		if (s < LO) return LO;
		return s;
	endfunction

	// Edge insertion with row and column pass, then I x J closure
	function automatic int unsigned close_edge(int unsigned a, int unsigned b, longint w);
		int unsigned cnt;
		longint c;
		cnt = 1;
		rows_i.delete();
		cols_j.delete();
		shadow[a][b] = w;
		for (int unsigned u = 0; u < NUM_VARS; u++) begin
			if (shadow[u][a] != INF) begin
				c = sat_sum(shadow[u][a], w);
				if (c < shadow[u][b]) begin
					shadow[u][b] = c;
					rows_i = {rows_i, u};
					cnt++;
				end
			end
			if (shadow[b][u] != INF) begin
				c = sat_sum(shadow[b][u], w);
				if (c < shadow[a][u]) begin
					shadow[a][u] = c;
					cols_j = {cols_j, u};
					cnt++;
				end
			end
		end
		foreach (rows_i[x]) begin
			foreach (cols_j[y]) begin
				if (rows_i[x] != cols_j[y]) begin
					c = sat_sum(shadow[rows_i[x]][b], shadow[b][cols_j[y]]);
					if (c < shadow[rows_i[x]][cols_j[y]]) begin
						shadow[rows_i[x]][cols_j[y]] = c;
						cnt++;
					end
				end
			end
		end
		return cnt;
	endfunction

	function automatic outcome_t predict_item(logic fn, int unsigned f, int unsigned t,
			longint bnd, logic neg);
		outcome_t o;
		int unsigned a, b, n;
		longint w, v;
		o = '0;
		if (fn == FUNC_READ) begin
			v = shadow[f][t];
			if (v == INF) o.dv = 32'sh7FFFFFFF;
			else if (v > 64'sd2147483646) o.dv = 32'sh7FFFFFFE;
			else if (v < -64'sd2147483647) o.dv = -32'sd2147483647;
			else o.dv = v[31:0];
			o.st = ST_OK;
		end else begin
			a = neg ? t : f;
			b = neg ? f : t;
			w = neg ? (-bnd - 1) : bnd;
			if (w > HI) w = HI;
			if (w < LO) w = LO;
			if (shadow[b][a] < -w) o.st = ST_CONFLICT;
			else if (shadow[a][b] <= w) o.st = ST_REDUNDANT;
			else begin
				o.st = ST_OK;
				n = close_edge(a, b, w);
				o.cnt = (n > 8191) ? 13'd8191 : n[CNT_W-1:0];
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			foreach (shadow[r, c]) shadow[r][c] = (r == c) ? 0 : INF;
			expected_q.delete();
			fail_count = 0;
			pending <= 0;
			results_seen <= 0;
			inserts_seen <= 0;
			conflicts_seen <= 0;
		end else begin
			if (done) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					report_mismatch("results waiting", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (status != e.st) report_mismatch("status", status, e.st);
					if (distance != e.dv) report_mismatch("distance", distance, e.dv);
					if (changed_entries != e.cnt)
						report_mismatch("changed_entries", changed_entries, e.cnt);
					if (e.st == ST_CONFLICT) conflicts_seen <= conflicts_seen + 1;
					if (e.cnt != 0) inserts_seen <= inserts_seen + 1;
				end
			end
			if (start && !busy)
				expected_q = {expected_q, predict_item(func, from_var, to_var,
					longint'(bound), negated)};
			pending <= expected_q.size();
		end
	end
endmodule

// ===== test/difference_constraint_apsp_update_top_tb.sv =====
// Testbench top: drives assert and read items into the block and gives the verdict.
`timescale 1ns / 100ps
module difference_constraint_apsp_update_top_tb;
	import dcau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = FUNC_ASSERT;
	logic [VAR_W-1:0] from_var = '0;
	logic [VAR_W-1:0] to_var = '0;
	logic signed [BOUND_W-1:0] bound = '0;
	logic negated = 1'b0;
	logic busy, done;
	logic [1:0] status;
	logic signed [OUT_W-1:0] distance;
	logic [CNT_W-1:0] changed_entries;
	int fail_count, pending, results_seen, inserts_seen, conflicts_seen;
	int sent;
	longint cycles = 0;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam logic signed [BOUND_W-1:0] B_MAX = 25'sh0FFFFFF;
	localparam logic signed [BOUND_W-1:0] B_MIN = -25'sh1000000;

	always #4 clk = ~clk;

	difference_constraint_apsp_update_top dut (.*);

	dcau_checker checker_i (.*);

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
		repeat (n) @(posedge clk);
	endtask

	// Hand one item over; start held until an edge with busy low
	task automatic send_item(logic fn, int unsigned f, int unsigned t, int b,
			int unsigned neg);
		func <= fn;
		from_var <= var_t'(f);
		to_var <= var_t'(t);
		bound <= BOUND_W'(b);
		negated <= neg[0];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b0;
		sent++;
		@(posedge clk);
		if ($urandom_range(0, 3) != 0) idle_gap();
	endtask

	// Small bound mostly, extremes now and then
	function automatic logic signed [BOUND_W-1:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return B_MAX;
			1: return B_MIN;
			2: return BOUND_W'($urandom);
			default: return $signed(25'($urandom_range(0, 40))) - 25'sd20;
		endcase
	endfunction

	initial begin
		int unsigned v0, v1;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads of reset state, self edges, extremes, conflicts
		send_item(FUNC_READ, 0, 0, 0, 0);
		send_item(FUNC_READ, 0, 63, 0, 0);
		send_item(FUNC_ASSERT, 5, 5, -1, 0);
		send_item(FUNC_ASSERT, 5, 5, 0, 0);
		send_item(FUNC_ASSERT, 0, 1, 10, 0);
		send_item(FUNC_ASSERT, 1, 2, 5, 0);
		send_item(FUNC_ASSERT, 0, 2, 20, 0);
		send_item(FUNC_ASSERT, 2, 0, -16, 0);
		send_item(FUNC_ASSERT, 3, 0, 2, 0);
		send_item(FUNC_READ, 3, 2, 0, 0);
		send_item(FUNC_ASSERT, 63, 62, B_MAX, 0);
		send_item(FUNC_ASSERT, 62, 61, B_MIN, 0);
		send_item(FUNC_ASSERT, 61, 60, B_MIN, 1);
		send_item(FUNC_ASSERT, 60, 63, B_MIN, 0);
		send_item(FUNC_ASSERT, 62, 63, B_MAX, 1);
		send_item(FUNC_READ, 63, 61, 0, 0);
		send_item(FUNC_READ, 61, 63, 0, 0);
		send_item(FUNC_ASSERT, 7, 8, 3, 1);
		send_item(FUNC_ASSERT, 8, 7, -5, 0);
		send_item(FUNC_READ, 7, 8, 0, 1);
		send_item(FUNC_ASSERT, 63, 0, B_MAX, 1);

		// Random: asserts and reads over a small variable pool, now and then the whole range
		repeat (120) begin
			v0 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
			v1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0)
				send_item(FUNC_READ, v0, v1, $urandom, $urandom_range(0, 1));
			else
				send_item(FUNC_ASSERT, v0, v1, pick_bound(), $urandom_range(0, 1));
		end

		while (pending != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d items, %0d results; %0d inserting asserts, %0d conflicts",
			sent, results_seen, inserts_seen, conflicts_seen);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/dcau_pkg.sv
hw/rtl/dcau_mem.sv
hw/rtl/dcau_lists.sv
hw/rtl/difference_constraint_apsp_update_top.sv
test/dcau_checker.sv
test/difference_constraint_apsp_update_top_tb.sv
